FILE: design/sra_pkg.sv
// ----------------------------------------------------------------------------
// sra_pkg
// Shared types, codes and helpers of the selective-repeat ARQ link engine.
// ----------------------------------------------------------------------------
package sra_pkg;

	localparam int SEQ_W   = 5;
	localparam int SLOT_W  = 4;
	localparam int PAY_W   = 32;
	localparam int LEN_W   = 10;
	localparam int DUR_W   = 16;
	localparam int OUTS_W  = 5;

	localparam logic [OUTS_W-1:0] WINDOW     = OUTS_W'(16);
	localparam logic [SEQ_W-1:0]  LIMIT_INIT = SEQ_W'(16);
	localparam logic [LEN_W-1:0]  LEN_HDR    = LEN_W'(7);
	localparam logic [DUR_W-1:0]  DATA_TO_RST = DUR_W'(3800);
	localparam logic [DUR_W-1:0]  ACK_TO_RST  = DUR_W'(1100);

	// event codes
	localparam logic [2:0] ACT_NEW    = 3'd0;
	localparam logic [2:0] ACT_PHYS   = 3'd1;
	localparam logic [2:0] ACT_RX     = 3'd2;
	localparam logic [2:0] ACT_ACKTO  = 3'd3;
	localparam logic [2:0] ACT_DATATO = 3'd4;

	// frame kinds
	localparam logic [1:0] FK_DATA = 2'd0;
	localparam logic [1:0] FK_ACK  = 2'd1;
	localparam logic [1:0] FK_NAK  = 2'd2;

	// result kinds
	localparam logic [2:0] OK_SEND    = 3'd0;
	localparam logic [2:0] OK_DELIVER = 3'd1;
	localparam logic [2:0] OK_DSTART  = 3'd2;
	localparam logic [2:0] OK_DSTOP   = 3'd3;
	localparam logic [2:0] OK_ASTART  = 3'd4;
	localparam logic [2:0] OK_ASTOP   = 3'd5;
	localparam logic [2:0] OK_NETEN   = 3'd6;

	// configuration register indexes
	localparam logic CFG_DATA_TO = 1'b0;
	localparam logic CFG_ACK_TO  = 1'b1;

	typedef struct packed {
		logic [2:0]        action;
		logic [PAY_W-1:0]  packet_in;
		logic              rx_crc_ok;
		logic [1:0]        rx_kind;
		logic [SEQ_W-1:0]  rx_seq;
		logic [SEQ_W-1:0]  rx_ack;
		logic [PAY_W-1:0]  rx_payload;
		logic [LEN_W-1:0]  rx_len;
		logic [SLOT_W-1:0] timeout_slot;
	} sra_event_t;

	typedef struct packed {
		logic [2:0]        out_kind;
		logic [1:0]        frame_kind;
		logic [SEQ_W-1:0]  frame_seq;
		logic [SEQ_W-1:0]  piggy_ack;
		logic [PAY_W-1:0]  payload_out;
		logic [LEN_W-1:0]  deliver_len;
		logic [SLOT_W-1:0] timer_slot;
		logic [DUR_W-1:0]  timer_duration;
		logic              network_enable;
		logic              last;
	} sra_result_t;

	typedef enum logic [2:0] {
		CLS_NEW, CLS_PHYS, CLS_RX, CLS_ACKTO, CLS_DATATO, CLS_NONE
	} sra_cls_t;

	typedef struct packed {
		sra_cls_t   cls;
		sra_event_t ev;
	} sra_cmd_t;

	// circular window test: b lies in [a, c)
	function automatic logic between(input logic [SEQ_W-1:0] a,
			input logic [SEQ_W-1:0] b, input logic [SEQ_W-1:0] c);
		return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
	endfunction

endpackage

FILE: design/sra_front.sv
// ----------------------------------------------------------------------------
// sra_front
// Accepts link events, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module sra_front import sra_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  sra_event_t event_item,
	output logic       cmd_valid,
	output sra_cmd_t   cmd,
	input  logic       cmd_take
);

	sra_cmd_t   mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       wr_en, rd_en;
	sra_cls_t   cls;

	// decode the event code
	always_comb begin
		unique case (event_item.action)
			ACT_NEW:    cls = CLS_NEW;
			ACT_PHYS:   cls = CLS_PHYS;
			ACT_RX:     cls = CLS_RX;
			ACT_ACKTO:  cls = CLS_ACKTO;
			ACT_DATATO: cls = CLS_DATATO;
			default:    cls = CLS_NONE;
		endcase
	end

	assign full      = (count_q == 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = mem_q[rd_ptr_q];
	assign wr_en     = push && !full;
	assign rd_en     = cmd_take && cmd_valid;

	// queue storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= '{cls: cls, ev: event_item};
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (wr_en) wr_ptr_q <= !wr_ptr_q;
			if (rd_en) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + 2'(wr_en) - 2'(rd_en);
		end
	end

endmodule

FILE: design/sra_engine.sv
// ----------------------------------------------------------------------------
// sra_engine
// Sequencer running one event, one result per cycle while the result queue
// has room, over send/receive windows, the frame buffers and arrival marks.
// ----------------------------------------------------------------------------
module sra_engine import sra_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  sra_cmd_t         cmd,
	output logic             cmd_take,
	input  logic [DUR_W-1:0] data_dur,
	input  logic [DUR_W-1:0] ack_dur,
	output logic             emit_valid,
	output sra_result_t      emit_item,
	input  logic             oq_full
);

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_FRAME, S_DTIMER, S_STOPACK, S_ACKSTART, S_STORE,
		S_DELIV, S_DSTART, S_NAKCHK, S_ACKLOOP, S_NE
	} state_t;

	state_t             state_q, ret_q;
	sra_cmd_t           cmd_q;
	logic [1:0]         fk_q;
	logic [SEQ_W-1:0]   fseq_q;
	logic [SEQ_W-1:0]   send_next_q, send_base_q, recv_base_q, recv_limit_q;
	logic [OUTS_W-1:0]  outstanding_q;
	logic               nak_allowed_q, phys_ready_q;
	logic [15:0]        arrived_q;
	logic [PAY_W-1:0]   out_store_q [16];
	logic [PAY_W-1:0]   in_store_q [16];
	logic [LEN_W-1:0]   in_len_q [16];

	logic               fire;
	logic               store_ok;
	logic [SEQ_W-1:0]   rx_seq, rx_ack, nak_seq, to_seq;
	logic [SLOT_W-1:0]  rb_slot;
	logic [LEN_W-1:0]   rb_len;

	assign rx_seq  = cmd_q.ev.rx_seq;
	assign rx_ack  = cmd_q.ev.rx_ack;
	assign nak_seq = rx_ack + SEQ_W'(1);
	assign rb_slot = recv_base_q[SLOT_W-1:0];
	assign rb_len  = in_len_q[rb_slot];
	// frame is new and inside the receive window
	assign store_ok = between(recv_base_q, rx_seq, recv_limit_q)
		&& !arrived_q[rx_seq[SLOT_W-1:0]];
	// stale data timeout moves up by one window
	assign to_seq  = between(send_base_q, {1'b0, cmd_q.ev.timeout_slot}, send_next_q)
		? {1'b0, cmd_q.ev.timeout_slot} : {1'b1, cmd_q.ev.timeout_slot};

	assign cmd_take = (state_q == S_IDLE) && cmd_valid;
	assign fire     = emit_valid && !oq_full;

	// result of the current step
	always_comb begin
		emit_valid = 1'b0;
		emit_item  = '0;
		unique case (state_q)
			S_FRAME: begin
				emit_valid           = 1'b1;
				emit_item.out_kind   = OK_SEND;
				emit_item.frame_kind = fk_q;
				emit_item.piggy_ack  = recv_base_q - SEQ_W'(1);
				if (fk_q == FK_DATA) begin
					emit_item.frame_seq   = fseq_q;
					emit_item.payload_out = out_store_q[fseq_q[SLOT_W-1:0]];
				end
			end
			S_DTIMER: begin
				emit_valid               = 1'b1;
				emit_item.out_kind       = OK_DSTART;
				emit_item.timer_slot     = fseq_q[SLOT_W-1:0];
				emit_item.timer_duration = data_dur;
			end
			S_STOPACK: begin
				emit_valid         = 1'b1;
				emit_item.out_kind = OK_ASTOP;
			end
			S_ACKSTART, S_DSTART: begin
				emit_valid               = 1'b1;
				emit_item.out_kind       = OK_ASTART;
				emit_item.timer_duration = ack_dur;
			end
			S_DELIV: begin
				emit_valid            = arrived_q[rb_slot];
				emit_item.out_kind    = OK_DELIVER;
				emit_item.payload_out = in_store_q[rb_slot];
				emit_item.deliver_len = (rb_len >= LEN_HDR) ? rb_len - LEN_HDR : '0;
			end
			S_ACKLOOP: begin
				emit_valid           = between(send_base_q, rx_ack, send_next_q);
				emit_item.out_kind   = OK_DSTOP;
				emit_item.timer_slot = send_base_q[SLOT_W-1:0];
			end
			S_NE: begin
				emit_valid               = 1'b1;
				emit_item.out_kind       = OK_NETEN;
				emit_item.network_enable = (outstanding_q < WINDOW) && phys_ready_q;
				emit_item.last           = 1'b1;
			end
			default: begin
				emit_valid = 1'b0;
			end
		endcase
	end

	// buffers
	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_q <= cmd;
		end
		if (state_q == S_DECODE && cmd_q.cls == CLS_NEW && outstanding_q < WINDOW) begin
			out_store_q[send_next_q[SLOT_W-1:0]] <= cmd_q.ev.packet_in;
		end
		if (state_q == S_STORE && store_ok) begin
			in_store_q[rx_seq[SLOT_W-1:0]] <= cmd_q.ev.rx_payload;
			in_len_q[rx_seq[SLOT_W-1:0]]   <= cmd_q.ev.rx_len;
		end
	end

	// sequencer and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			ret_q         <= S_NE;
			fk_q          <= FK_DATA;
			fseq_q        <= '0;
			send_next_q   <= '0;
			send_base_q   <= '0;
			recv_base_q   <= '0;
			recv_limit_q  <= LIMIT_INIT;
			outstanding_q <= '0;
			nak_allowed_q <= 1'b1;
			phys_ready_q  <= 1'b0;
			arrived_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) state_q <= S_DECODE;
				end
				S_DECODE: begin
					ret_q   <= S_NE;
					state_q <= S_NE;
					unique case (cmd_q.cls)
						CLS_NEW: begin
							if (outstanding_q < WINDOW) begin
								outstanding_q <= outstanding_q + OUTS_W'(1);
								fk_q          <= FK_DATA;
								fseq_q        <= send_next_q;
								send_next_q   <= send_next_q + SEQ_W'(1);
								state_q       <= S_FRAME;
							end
						end
						CLS_PHYS: phys_ready_q <= 1'b1;
						CLS_RX: begin
							if (!cmd_q.ev.rx_crc_ok) begin
								if (nak_allowed_q) begin
									fk_q    <= FK_NAK;
									state_q <= S_FRAME;
								end
							end else if (cmd_q.ev.rx_kind == FK_DATA) begin
								if (rx_seq != recv_base_q && nak_allowed_q) begin
									fk_q    <= FK_NAK;
									ret_q   <= S_STORE;
									state_q <= S_FRAME;
								end else begin
									state_q <= S_ACKSTART;
								end
							end else begin
								state_q <= S_NAKCHK;
							end
						end
						CLS_ACKTO: begin
							fk_q    <= FK_ACK;
							state_q <= S_FRAME;
						end
						CLS_DATATO: begin
							fk_q    <= FK_DATA;
							fseq_q  <= to_seq;
							state_q <= S_FRAME;
						end
						default: state_q <= S_NE;
					endcase
				end
				S_FRAME: begin
					if (fire) begin
						phys_ready_q <= 1'b0;
						if (fk_q == FK_NAK) nak_allowed_q <= 1'b0;
						state_q <= (fk_q == FK_DATA) ? S_DTIMER : S_STOPACK;
					end
				end
				S_DTIMER: begin
					if (fire) state_q <= S_STOPACK;
				end
				S_STOPACK: begin
					if (fire) state_q <= ret_q;
				end
				S_ACKSTART: begin
					if (fire) state_q <= S_STORE;
				end
				S_STORE: begin
					// the store itself sits in the buffer block
					if (store_ok) begin
						arrived_q[rx_seq[SLOT_W-1:0]] <= 1'b1;
						state_q <= S_DELIV;
					end else begin
						state_q <= S_NAKCHK;
					end
				end
				S_DELIV: begin
					if (!arrived_q[rb_slot]) begin
						state_q <= S_NAKCHK;
					end else if (fire) begin
						nak_allowed_q      <= 1'b1;
						arrived_q[rb_slot] <= 1'b0;
						recv_base_q        <= recv_base_q + SEQ_W'(1);
						recv_limit_q       <= recv_limit_q + SEQ_W'(1);
						state_q            <= S_DSTART;
					end
				end
				S_DSTART: begin
					if (fire) state_q <= S_DELIV;
				end
				S_NAKCHK: begin
					if (cmd_q.ev.rx_kind == FK_NAK
							&& between(send_base_q, nak_seq, send_next_q)) begin
						fk_q    <= FK_DATA;
						fseq_q  <= nak_seq;
						ret_q   <= S_ACKLOOP;
						state_q <= S_FRAME;
					end else begin
						state_q <= S_ACKLOOP;
					end
				end
				S_ACKLOOP: begin
					if (!emit_valid) begin
						state_q <= S_NE;
					end else if (fire) begin
						if (outstanding_q != '0) outstanding_q <= outstanding_q - OUTS_W'(1);
						send_base_q <= send_base_q + SEQ_W'(1);
					end
				end
				S_NE: begin
					if (fire) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: design/sra_outq.sv
// ----------------------------------------------------------------------------
// sra_outq
// Four-entry result queue between the sequencer and the result port.
// ----------------------------------------------------------------------------
module sra_outq import sra_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_valid,
	input  sra_result_t wr_item,
	output logic        oq_full,
	output logic        empty,
	input  logic        pop,
	output sra_result_t result_item
);

	sra_result_t mem_q [4];
	logic [1:0]  wr_ptr_q, rd_ptr_q;
	logic [2:0]  count_q;
	logic        wr_en, rd_en;

	assign oq_full     = (count_q == 3'd4);
	assign empty       = (count_q == 3'd0);
	assign result_item = mem_q[rd_ptr_q];
	assign wr_en       = wr_valid && !oq_full;
	assign rd_en       = pop && !empty;

	// storage
	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q] <= wr_item;
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= wr_ptr_q + 2'd1;
			if (rd_en) rd_ptr_q <= rd_ptr_q + 2'd1;
			count_q <= count_q + 3'(wr_en) - 3'(rd_en);
		end
	end

endmodule

FILE: design/selective_repeat_arq_top.sv
// The sequencer takes and decodes an event, then issues its results in turn
// with bookkeeping steps between, the delivery and ack loops walking the
// window one slot per result. The next event waits in a two-entry queue;
// results leave through a four-entry queue. Reset (asynchronous, active
// low) empties both queues and restores windows, arrival marks and timeout
// registers; the frame buffers keep no reset.
// ----------------------------------------------------------------------------
// selective_repeat_arq_top
// Selective-repeat ARQ link engine with a 16-slot window.
// ----------------------------------------------------------------------------
module selective_repeat_arq_top import sra_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  sra_event_t       event_item,
	output logic             empty,
	input  logic             pop,
	output sra_result_t      result_item,
	input  logic             cfg_write,
	input  logic             cfg_addr,
	input  logic [DUR_W-1:0] cfg_data
);

	logic             cmd_valid, cmd_take, emit_valid, oq_full;
	sra_cmd_t         cmd;
	sra_result_t      emit_item;
	logic [DUR_W-1:0] data_dur_q, ack_dur_q;

	// timeout registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_dur_q <= DATA_TO_RST;
			ack_dur_q  <= ACK_TO_RST;
		end else if (cfg_write) begin
			unique case (cfg_addr)
				CFG_DATA_TO: data_dur_q <= cfg_data;
				CFG_ACK_TO:  ack_dur_q  <= cfg_data;
				default:     data_dur_q <= data_dur_q;
			endcase
		end
	end

	sra_front u_front (
		.clk, .arst_n, .push, .full, .event_item,
		.cmd_valid, .cmd, .cmd_take
	);

	sra_engine u_engine (
		.clk, .arst_n, .cmd_valid, .cmd, .cmd_take,
		.data_dur(data_dur_q), .ack_dur(ack_dur_q),
		.emit_valid, .emit_item, .oq_full
	);

	sra_outq u_outq (
		.clk, .arst_n, .wr_valid(emit_valid), .wr_item(emit_item), .oq_full,
		.empty, .pop, .result_item
	);

endmodule

FILE: design/sra_checker.sv
// ----------------------------------------------------------------------------
// sra_checker
// Port-level checks of the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module sra_checker import sra_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input sra_result_t result_item
);

	// only the network enable result closes an event
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (result_item.last == (result_item.out_kind == OK_NETEN)))
		else $error("last flag on wrong result");

	// frame fields stay zero outside send results
	a_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result_item.out_kind != OK_SEND) |->
		(result_item.frame_kind == '0 && result_item.frame_seq == '0
			&& result_item.piggy_ack == '0))
		else $error("frame fields set on non-send result");

	// durations only on start commands
	a_dur: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result_item.out_kind != OK_DSTART && result_item.out_kind != OK_ASTART)
		|-> result_item.timer_duration == '0)
		else $error("duration on non-start result");

	// a waiting result stays
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(result_item)))
		else $error("waiting result lost");

endmodule

bind selective_repeat_arq_top sra_checker u_checker (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop), .result_item(result_item)
);

FILE: bench/sra_link_checker.sv
// ----------------------------------------------------------------------------
// sra_link_checker
// Watches the event and result queues of the ARQ link engine, keeps its own
// copy of the windows, buffers and timeout registers, works out the results
// of every accepted item and compares each popped result field by field.
// ----------------------------------------------------------------------------
module sra_link_checker import sra_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic             full,
	input  sra_event_t       event_item,
	input  logic             empty,
	input  logic             pop,
	input  sra_result_t      result_item,
	input  logic             cfg_write,
	input  logic             cfg_addr,
	input  logic [DUR_W-1:0] cfg_data,
	output int               errors,
	output int               pending,
	output logic [SEQ_W-1:0] tx_base,
	output logic [SEQ_W-1:0] tx_next,
	output logic [SEQ_W-1:0] rx_base,
	output logic [OUTS_W-1:0] in_flight,
	output logic [15:0]      slot_written
);

	// mirrored link state
	logic [SEQ_W-1:0]  rx_limit;
	logic [PAY_W-1:0]  tx_buf [16];
	logic [PAY_W-1:0]  rx_buf [16];
	logic [LEN_W-1:0]  rx_len_buf [16];
	logic [15:0]       got_mark;
	logic              nak_ok;
	logic              phy_rdy;
	logic [DUR_W-1:0]  data_dur;
	logic [DUR_W-1:0]  ack_dur;
	sra_result_t       expected_results [$];

	assign pending = expected_results.size();

	// b lies in the circular range [a, c)
	function automatic logic in_range(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b,
			logic [SEQ_W-1:0] c);
		if (a <= c)
			return (a <= b) && (b < c);
		return (b >= a) || (b < c);
	endfunction

	task automatic add_result(logic [2:0] kind, logic [1:0] fk, logic [SEQ_W-1:0] seq,
			logic [SEQ_W-1:0] ack, logic [PAY_W-1:0] pay, logic [LEN_W-1:0] dlen,
			logic [SLOT_W-1:0] slot, logic [DUR_W-1:0] dur, logic ne, logic fin);
		sra_result_t r;
		r = '{kind, fk, seq, ack, pay, dlen, slot, dur, ne, fin};
		expected_results.push_back(r);
	endtask

	task automatic transmit(logic [1:0] fk, logic [SEQ_W-1:0] seq);
		logic [SEQ_W-1:0] piggy;
		piggy = rx_base - 1'b1;
		if (fk == FK_DATA) begin
			add_result(OK_SEND, FK_DATA, seq, piggy, tx_buf[seq[3:0]], '0, '0, '0, 0, 0);
		end else begin
			if (fk == FK_NAK)
				nak_ok = 0;
			add_result(OK_SEND, fk, '0, piggy, '0, '0, '0, '0, 0, 0);
		end
		phy_rdy = 0;
		if (fk == FK_DATA)
			add_result(OK_DSTART, '0, '0, '0, '0, '0, seq[3:0], data_dur, 0, 0);
		add_result(OK_ASTOP, '0, '0, '0, '0, '0, '0, '0, 0, 0);
	endtask

	task automatic take_frame(sra_event_t e);
		logic [SEQ_W-1:0] nak_seq;
		logic [3:0] s;
		nak_seq = e.rx_ack + 1'b1;
		// bad checksum: at most a nak, nothing else moves
		if (!e.rx_crc_ok) begin
			if (nak_ok)
				transmit(FK_NAK, '0);
			return;
		end
		if (e.rx_kind == FK_DATA) begin
			if (e.rx_seq != rx_base && nak_ok)
				transmit(FK_NAK, '0);
			else
				add_result(OK_ASTART, '0, '0, '0, '0, '0, '0, ack_dur, 0, 0);
			if (in_range(rx_base, e.rx_seq, rx_limit) && !got_mark[e.rx_seq[3:0]]) begin
				got_mark[e.rx_seq[3:0]] = 1;
				rx_buf[e.rx_seq[3:0]] = e.rx_payload;
				rx_len_buf[e.rx_seq[3:0]] = e.rx_len;
				// hand over everything now in order
				while (got_mark[rx_base[3:0]]) begin
					s = rx_base[3:0];
					add_result(OK_DELIVER, '0, '0, '0, rx_buf[s],
						(rx_len_buf[s] >= LEN_HDR) ? rx_len_buf[s] - LEN_HDR : '0,
						'0, '0, 0, 0);
					nak_ok = 1;
					got_mark[s] = 0;
					rx_base = rx_base + 1'b1;
					rx_limit = rx_limit + 1'b1;
					add_result(OK_ASTART, '0, '0, '0, '0, '0, '0, ack_dur, 0, 0);
				end
			end
		end
		if (e.rx_kind == FK_NAK && in_range(tx_base, nak_seq, tx_next))
			transmit(FK_DATA, nak_seq);
		// cumulative ack slides the send window
		while (in_range(tx_base, e.rx_ack, tx_next)) begin
			if (in_flight > 0)
				in_flight = in_flight - 1'b1;
			add_result(OK_DSTOP, '0, '0, '0, '0, '0, tx_base[3:0], '0, 0, 0);
			tx_base = tx_base + 1'b1;
		end
	endtask

	task automatic predict_event(sra_event_t e);
		logic [SEQ_W-1:0] seq;
		case (e.action)
			ACT_NEW: begin
				if (in_flight < WINDOW) begin
					in_flight = in_flight + 1'b1;
					tx_buf[tx_next[3:0]] = e.packet_in;
					slot_written[tx_next[3:0]] = 1;
					transmit(FK_DATA, tx_next);
					tx_next = tx_next + 1'b1;
				end
			end
			ACT_PHYS: phy_rdy = 1;
			ACT_RX: take_frame(e);
			ACT_ACKTO: transmit(FK_ACK, '0);
			ACT_DATATO: begin
				seq = {1'b0, e.timeout_slot};
				if (!in_range(tx_base, seq, tx_next))
					seq = seq + 5'd16;
				transmit(FK_DATA, seq);
			end
			default: ;
		endcase
		add_result(OK_NETEN, '0, '0, '0, '0, '0, '0, '0, (in_flight < WINDOW) && phy_rdy, 1);
	endtask

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch %s: got %0h expected %0h", what, got, want);
	endtask

	task automatic compare_result(sra_result_t got);
		sra_result_t want;
		if (expected_results.size() == 0) begin
			report("unexpected result", got.out_kind, 0);
			return;
		end
		want = expected_results.pop_front();
		if (got.out_kind != want.out_kind)
			report("out_kind", got.out_kind, want.out_kind);
		if (got.frame_kind != want.frame_kind)
			report("frame_kind", got.frame_kind, want.frame_kind);
		if (got.frame_seq != want.frame_seq)
			report("frame_seq", got.frame_seq, want.frame_seq);
		if (got.piggy_ack != want.piggy_ack)
			report("piggy_ack", got.piggy_ack, want.piggy_ack);
		if (got.payload_out != want.payload_out)
			report("payload_out", got.payload_out, want.payload_out);
		if (got.deliver_len != want.deliver_len)
			report("deliver_len", got.deliver_len, want.deliver_len);
		if (got.timer_slot != want.timer_slot)
			report("timer_slot", got.timer_slot, want.timer_slot);
		if (got.timer_duration != want.timer_duration)
			report("timer_duration", got.timer_duration, want.timer_duration);
		if (got.network_enable != want.network_enable)
			report("network_enable", got.network_enable, want.network_enable);
		if (got.last != want.last)
			report("last", got.last, want.last);
	endtask

	// sample all channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			errors = 0;
			tx_base = '0;
			tx_next = '0;
			rx_base = '0;
			rx_limit = LIMIT_INIT;
			in_flight = '0;
			got_mark = '0;
			slot_written = '0;
			nak_ok = 1;
			phy_rdy = 0;
			data_dur = DATA_TO_RST;
			ack_dur = ACK_TO_RST;
			expected_results.delete();
		end else begin
			if (cfg_write) begin
				if (cfg_addr == CFG_DATA_TO)
					data_dur = cfg_data;
				else
					ack_dur = cfg_data;
			end
			if (push && !full)
				predict_event(event_item);
			if (pop && !empty)
				compare_result(result_item);
		end
	end

endmodule

FILE: bench/selective_repeat_arq_top_test.sv
// ----------------------------------------------------------------------------
// selective_repeat_arq_top_test
// Drives link events into the ARQ engine: a directed opening, then three
// random phases with different idling on both queues and changing timeout
// registers. The checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module selective_repeat_arq_top_test;
	import sra_pkg::*;

	localparam int CYCLE_LIMIT = 600000;

	logic             clk;
	logic             arst_n;
	logic             push;
	logic             full;
	sra_event_t       event_item;
	logic             empty;
	logic             pop;
	sra_result_t      result_item;
	logic             cfg_write;
	logic             cfg_addr;
	logic [DUR_W-1:0] cfg_data;

	int               errors;
	int               pending;
	logic [SEQ_W-1:0] tx_base;
	logic [SEQ_W-1:0] tx_next;
	logic [SEQ_W-1:0] rx_base;
	logic [OUTS_W-1:0] in_flight;
	logic [15:0]      slot_written;

	int               send_idle_pct;
	int               recv_idle_pct;
	logic             hold_req;
	int               cycles;

	selective_repeat_arq_top dut (.*);

	sra_link_checker checker_i (.*);

	// clock
	initial clk = 0;
	always #6 clk = ~clk;

	// run limit
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// result side: random pops, with one long hold-off on request
	initial begin
		pop = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				pop = 0;
				repeat (400) @(negedge clk);
				hold_req = 0;
			end
			pop = ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// full is stable from the falling edge on, so the next rising edge takes the item
	task automatic send_event(sra_event_t e);
		if ($urandom_range(0, 99) < send_idle_pct)
			repeat ($urandom_range(1, 5)) @(negedge clk);
		event_item = e;
		push = 1;
		while (full)
			@(negedge clk);
		@(negedge clk);
		push = 0;
	endtask

	task automatic write_reg(logic addr, logic [DUR_W-1:0] value);
		cfg_write = 1;
		cfg_addr = addr;
		cfg_data = value;
		@(negedge clk);
		cfg_write = 0;
	endtask

	// let every result drain, then allow the sequencer to settle
	task automatic wait_drained();
		while (pending != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	function automatic sra_event_t quiet_event(logic [2:0] act);
		sra_event_t e;
		e = '0;
		e.action = act;
		return e;
	endfunction

	function automatic sra_event_t rx_event(logic crc, logic [1:0] kind, logic [SEQ_W-1:0] seq,
			logic [SEQ_W-1:0] ack, logic [PAY_W-1:0] pay, logic [LEN_W-1:0] len);
		sra_event_t e;
		e = '0;
		e.packet_in = $urandom();
		e.timeout_slot = SLOT_W'($urandom());
		e.action = ACT_RX;
		e.rx_crc_ok = crc;
		e.rx_kind = kind;
		e.rx_seq = seq;
		e.rx_ack = ack;
		e.rx_payload = pay;
		e.rx_len = len;
		return e;
	endfunction

	// mostly well-formed traffic that follows the windows, some noise
	function automatic sra_event_t random_event();
		sra_event_t e;
		logic [95:0] noise;
		int pick;
		int slot;
		logic [SEQ_W-1:0] ack;
		logic [1:0] kind;
		noise = {$urandom(), $urandom(), $urandom()};
		e = noise[$bits(sra_event_t)-1:0];
		pick = $urandom_range(0, 99);
		if (pick < 28) begin
			e.action = ACT_NEW;
		end else if (pick < 38) begin
			e.action = ACT_PHYS;
		end else if (pick < 84) begin
			e.action = ACT_RX;
			e.rx_crc_ok = ($urandom_range(0, 99) < 88);
			pick = $urandom_range(0, 99);
			kind = (pick < 50) ? FK_DATA : (pick < 75) ? FK_ACK : (pick < 95) ? FK_NAK : 2'd3;
			e.rx_kind = kind;
			if ($urandom_range(0, 99) < 85)
				e.rx_seq = rx_base + SEQ_W'($urandom_range(0, 3));
			if (in_flight > 0 && $urandom_range(0, 99) < 80)
				ack = tx_base + SEQ_W'($urandom_range(0, in_flight - 1));
			else
				ack = tx_base - 1'b1;
			e.rx_ack = (kind == FK_NAK) ? ack - 1'b1 : ack;
			if ($urandom_range(0, 9) == 0)
				e.rx_ack = SEQ_W'($urandom());
		end else if (pick < 89) begin
			e.action = ACT_ACKTO;
		end else if (pick < 96 && slot_written != 0) begin
			e.action = ACT_DATATO;
			do slot = $urandom_range(0, 15); while (!slot_written[slot]);
			e.timeout_slot = SLOT_W'(slot);
		end else begin
			e.action = 3'($urandom_range(5, 7));
		end
		return e;
	endfunction

	task automatic random_phase(int count, int s_idle, int r_idle);
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		repeat (count) send_event(random_event());
	endtask

	// stimulus
	initial begin
		sra_event_t e;
		arst_n = 0;
		push = 0;
		event_item = '0;
		cfg_write = 0;
		cfg_addr = CFG_DATA_TO;
		cfg_data = '0;
		hold_req = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		repeat (2) @(negedge clk);

		// directed opening at the register extremes
		write_reg(CFG_DATA_TO, 16'd1);
		write_reg(CFG_ACK_TO, 16'hFFFF);
		send_event(quiet_event(ACT_ACKTO));
		send_event(quiet_event(ACT_PHYS));
		e = quiet_event(ACT_NEW);
		e.packet_in = 32'hFFFF_FFFF;
		send_event(e);
		e.packet_in = 32'h0;
		send_event(e);
		send_event(quiet_event(ACT_PHYS));
		// data timeouts for both slots inside the window
		e = quiet_event(ACT_DATATO);
		e.timeout_slot = 4'd1;
		send_event(e);
		e.timeout_slot = 4'd0;
		send_event(e);
		// out-of-order data, then the gap filled, short and longest lengths
		send_event(rx_event(1, FK_DATA, 5'd1, 5'd31, 32'hA5A5_5A5A, 10'd3));
		send_event(rx_event(1, FK_DATA, 5'd0, 5'd0, 32'hFFFF_FFFF, 10'd1023));
		send_event(rx_event(1, FK_DATA, 5'd31, 5'd31, 32'h0, 10'd0));
		// bad checksum, nak, unknown frame kind, ack
		send_event(rx_event(0, FK_DATA, 5'd2, 5'd1, 32'h1234_5678, 10'd7));
		send_event(rx_event(1, FK_NAK, 5'd0, 5'd31, 32'h0, 10'd5));
		send_event(rx_event(1, 2'd3, 5'd31, 5'd0, 32'h0, 10'd5));
		send_event(rx_event(1, FK_ACK, 5'd0, 5'd1, 32'h0, 10'd5));
		// fill the window past full
		e = quiet_event(ACT_NEW);
		repeat (17) begin
			e.packet_in = $urandom();
			send_event(e);
		end
		send_event(quiet_event(3'd5));
		send_event(quiet_event(3'd7));
		wait_drained();

		// phase one: long receiver hold-off fills the block
		write_reg(CFG_DATA_TO, 16'hFFFF);
		write_reg(CFG_ACK_TO, 16'd1);
		hold_req = 1;
		random_phase(110, 32, 64);
		wait_drained();

		write_reg(CFG_DATA_TO, DUR_W'($urandom_range(1, 65535)));
		write_reg(CFG_ACK_TO, DUR_W'($urandom_range(1, 65535)));
		random_phase(110, 64, 32);
		wait_drained();

		write_reg(CFG_DATA_TO, DATA_TO_RST);
		write_reg(CFG_ACK_TO, ACK_TO_RST);
		random_phase(100, 0, 0);
		wait_drained();

		if (errors == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
